// ===== rtl/core/tbdl_pkg.sv =====
// Types, codes and constants shared by the tape block deframer and lister.
// No dependencies; every other file of the block but tbdl_channels imports this package.
`default_nettype none
package tbdl_pkg;

   localparam int TBDL_QUEUE_DEPTH = 4;

   localparam logic [15:0] HEADER_LEN    = 16'd19;
   localparam logic [15:0] MIN_DATA_LEN  = 16'd2;
   localparam logic [7:0]  HEADER_FLAG   = 8'h00;
   localparam logic [7:0]  DATA_FLAG     = 8'hff;
   localparam logic [7:0]  CODE_TYPE     = 8'h03;
   localparam logic [15:0] SCREEN_BASE   = 16'h4000;
   localparam logic [15:0] SCREEN_SIZE   = 16'd6912;
   localparam logic [15:0] ATTR_BASE     = 16'h5800;
   localparam logic [15:0] ATTR_SIZE     = 16'd768;
   localparam logic [15:0] PROG_BASE     = 16'h5b00;
   localparam logic [15:0] COUNT_MAX     = 16'hffff;

   typedef enum logic [1:0] {
      PH_LEN_LO,
      PH_LEN_HI,
      PH_BODY
   } phase_type;

   typedef enum logic [2:0] {
      KIND_HEADER,
      KIND_PAIRED,
      KIND_RAW,
      KIND_NONROM,
      KIND_TRUNC,
      KIND_TRAIL
   } kind_type;

   typedef enum logic [2:0] {
      ROLE_NONE,
      ROLE_FULL_SCREEN,
      ROLE_SCREEN_DATA,
      ROLE_BITMAP,
      ROLE_ATTRS,
      ROLE_PART_ATTRS,
      ROLE_PROGRAM,
      ROLE_OTHER
   } role_type;

   typedef struct packed {
      logic [15:0] p2;
      logic [15:0] p1;
      logic [15:0] dlen;
      logic [7:0]  btype;
   } hdr_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] number;
      logic [7:0]  btype;
      logic [15:0] pay;
      logic [15:0] decl;
      logic [15:0] p1;
      logic [15:0] p2;
      logic        last;
   } entry_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   typedef struct packed {
      logic not_empty;
      logic room_two;
   } qstat_type;

endpackage
`default_nettype wire

// ===== rtl/core/tbdl_channels.sv =====
// Handshake channels of the tape block deframer: byte input and entry output.
// Standalone; no package dependency.
`default_nettype none
interface tbdl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] tape_byte;
   logic       end_of_file;
   modport source (output valid, tape_byte, end_of_file, input ready);
   modport sink (input valid, tape_byte, end_of_file, output ready);
endinterface

interface tbdl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  entry_kind;
   logic [15:0] entry_number;
   logic [7:0]  block_type;
   logic [2:0]  code_role;
   logic [15:0] entry_size;
   logic [15:0] declared_length;
   logic [15:0] first_param;
   logic [15:0] second_param;
   logic        last_of_run;
   modport source (output valid, entry_kind, entry_number, block_type, code_role,
                   entry_size, declared_length, first_param, second_param,
                   last_of_run, input ready);
   modport sink (input valid, entry_kind, entry_number, block_type, code_role,
                 entry_size, declared_length, first_param, second_param,
                 last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tbdl_front.sv =====
// Front end: accepts tape bytes, frames blocks, checks them and builds up to
// two list entries per byte. Depends on tbdl_pkg and tbdl_req_if.
`default_nettype none
module tbdl_front
   import tbdl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   tbdl_req_if.sink  req_chan,
   input  qstat_type q_stat,
   output push_type  push,
   output entry_type entry0,
   output entry_type entry1
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  length_low_ff, length_low_in;
   logic [15:0] block_length_ff, block_length_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  flag_ff, flag_in;
   hdr_type     capt_ff, capt_in;
   hdr_type     pend_ff, pend_in;
   logic        pend_v_ff, pend_v_in;
   logic [15:0] count_ff, count_in;

   logic        acc, eof;
   logic [7:0]  b;
   logic [15:0] len_hi, pos_n, fin_len, c1, c2;
   logic [7:0]  xor_n, flag_n;
   hdr_type     capt_n;
   logic        fin, good, hdr_blk, data_blk, paired, trunc, trail, err;
   logic        a_v, b_v;
   entry_type   ent_a, ent_b;

   function automatic entry_type hdr_entry(kind_type k, logic [15:0] num, hdr_type h,
                                           logic [15:0] pay);
      entry_type e;
      e.kind   = k;
      e.number = num;
      e.btype  = h.btype;
      e.pay    = pay;
      e.decl   = h.dlen;
      e.p1     = h.p1;
      e.p2     = h.p2;
      e.last   = 1'b0;
      return e;
   endfunction

   function automatic entry_type plain_entry(kind_type k, logic [15:0] num,
                                             logic [15:0] pay, logic [15:0] decl);
      entry_type e;
      e.kind   = k;
      e.number = num;
      e.btype  = '0;
      e.pay    = pay;
      e.decl   = decl;
      e.p1     = '0;
      e.p2     = '0;
      e.last   = 1'b0;
      return e;
   endfunction

   assign req_chan.ready = q_stat.room_two;
   assign acc = req_chan.valid & req_chan.ready;
   assign b   = req_chan.tape_byte;
   assign eof = req_chan.end_of_file;

   always_comb begin
      phase_in = phase_ff;
      if (acc) begin
         if (eof) begin
            phase_in = PH_LEN_LO;
         end else begin
            case (phase_ff)
               PH_LEN_LO: phase_in = PH_LEN_HI;
               PH_LEN_HI: phase_in = (len_hi == '0) ? PH_LEN_LO : PH_BODY;
               PH_BODY:   phase_in = fin ? PH_LEN_LO : PH_BODY;
               default:   phase_in = PH_LEN_LO;
            endcase
         end
      end
   end

   always_comb begin
      len_hi = {b, length_low_ff};
      pos_n  = pos_ff + 16'd1;
      xor_n  = xor_ff ^ b;
      flag_n = (pos_ff == '0) ? b : flag_ff;
      capt_n = capt_ff;
      case (pos_ff)
         16'd1:   capt_n.btype      = b;
         16'd12:  capt_n.dlen[7:0]  = b;
         16'd13:  capt_n.dlen[15:8] = b;
         16'd14:  capt_n.p1[7:0]    = b;
         16'd15:  capt_n.p1[15:8]   = b;
         16'd16:  capt_n.p2[7:0]    = b;
         16'd17:  capt_n.p2[15:8]   = b;
         default: capt_n = capt_ff;
      endcase

      fin     = ((phase_ff == PH_LEN_HI) && (len_hi == '0)) ||
                ((phase_ff == PH_BODY) && (pos_n == block_length_ff));
      fin_len = (phase_ff == PH_BODY) ? block_length_ff : '0;
      good    = (phase_ff == PH_BODY) && (xor_n == '0);
      hdr_blk = fin && good && (fin_len == HEADER_LEN) && (flag_n == HEADER_FLAG);
      data_blk = fin && good && !hdr_blk && (fin_len >= MIN_DATA_LEN) &&
                 (flag_n == DATA_FLAG);
      paired  = data_blk && pend_v_ff && (pend_ff.dlen == fin_len - MIN_DATA_LEN);
      trail   = eof && (phase_ff == PH_LEN_LO);
      trunc   = eof && (((phase_ff == PH_LEN_HI) && (len_hi != '0)) ||
                        ((phase_ff == PH_BODY) && !fin));
      err     = trail || trunc;

      c1 = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;
      c2 = (c1 == COUNT_MAX) ? c1 : c1 + 16'd1;

      a_v   = fin && pend_v_ff && !paired;
      ent_a = hdr_entry(KIND_HEADER, count_ff, pend_ff, pend_ff.dlen);
      b_v   = (fin && !hdr_blk) || (hdr_blk && eof) || err;

      if (trail) begin
         ent_b = plain_entry(KIND_TRAIL, '0, '0, '0);
      end else if (trunc) begin
         ent_b = plain_entry(KIND_TRUNC, '0, (phase_ff == PH_BODY) ? pos_n : '0,
                             (phase_ff == PH_BODY) ? block_length_ff : len_hi);
      end else if (hdr_blk) begin
         ent_b = hdr_entry(KIND_HEADER, a_v ? c1 : count_ff, capt_n, capt_n.dlen);
      end else if (paired) begin
         ent_b = hdr_entry(KIND_PAIRED, count_ff, pend_ff, fin_len - MIN_DATA_LEN);
      end else if (data_blk) begin
         ent_b = plain_entry(KIND_RAW, a_v ? c1 : count_ff, fin_len - MIN_DATA_LEN, '0);
      end else begin
         ent_b = plain_entry(KIND_NONROM, a_v ? c1 : count_ff, fin_len, '0);
      end

      entry0      = a_v ? ent_a : ent_b;
      entry0.last = !(a_v && b_v);
      entry1      = ent_b;
      entry1.last = 1'b1;
      push.first  = acc && (a_v || b_v);
      push.second = acc && a_v && b_v;

      length_low_in   = length_low_ff;
      block_length_in = block_length_ff;
      pos_in          = pos_ff;
      xor_in          = xor_ff;
      flag_in         = flag_ff;
      capt_in         = capt_ff;
      pend_in         = pend_ff;
      pend_v_in       = pend_v_ff;
      count_in        = count_ff;
      if (acc) begin
         case (phase_ff)
            PH_LEN_LO: length_low_in = b;
            PH_LEN_HI: begin
               block_length_in = len_hi;
               pos_in          = '0;
               xor_in          = '0;
               flag_in         = '0;
               capt_in         = '0;
            end
            PH_BODY: begin
               pos_in  = pos_n;
               xor_in  = xor_n;
               flag_in = flag_n;
               capt_in = capt_n;
            end
            default: pos_in = pos_ff;
         endcase
         if (fin) begin
            pend_v_in = hdr_blk;
            if (hdr_blk) begin
               pend_in = capt_n;
            end
         end
         if (a_v && b_v && !err) begin
            count_in = c2;
         end else if (a_v || (b_v && !err)) begin
            count_in = c1;
         end
         if (eof) begin
            length_low_in   = '0;
            block_length_in = '0;
            pos_in          = '0;
            xor_in          = '0;
            flag_in         = '0;
            capt_in         = '0;
            pend_in         = '0;
            pend_v_in       = 1'b0;
            count_in        = 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_LEN_LO;
         length_low_ff   <= '0;
         block_length_ff <= '0;
         pos_ff          <= '0;
         xor_ff          <= '0;
         flag_ff         <= '0;
         capt_ff         <= '0;
         pend_ff         <= '0;
         pend_v_ff       <= 1'b0;
         count_ff        <= 16'd1;
      end else begin
         phase_ff        <= phase_in;
         length_low_ff   <= length_low_in;
         block_length_ff <= block_length_in;
         pos_ff          <= pos_in;
         xor_ff          <= xor_in;
         flag_ff         <= flag_in;
         capt_ff         <= capt_in;
         pend_ff         <= pend_in;
         pend_v_ff       <= pend_v_in;
         count_ff        <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/tbdl_queue.sv =====
// Entry queue between front and back: two writes and one read per cycle.
// Depends on tbdl_pkg.
`default_nettype none
module tbdl_queue
   import tbdl_pkg::*;
#(
   parameter int DEPTH = TBDL_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  entry_type entry0,
   input  entry_type entry1,
   input  logic      pop,
   output entry_type head,
   output qstat_type q_stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_nx;
   logic [CW-1:0]   count_ff, count_in;

   function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign wr_ptr_nx        = ptr_inc(wr_ptr_ff);
   assign head             = mem_ff[rd_ptr_ff];
   assign q_stat.not_empty = (count_ff != '0);
   assign q_stat.room_two  = (count_ff <= CW'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.second) begin
         wr_ptr_in = ptr_inc(wr_ptr_nx);
      end else if (push.first) begin
         wr_ptr_in = wr_ptr_nx;
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.first) + CW'(push.second) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ptr_ff] <= entry0;
      end
      if (push.second) begin
         mem_ff[wr_ptr_nx] <= entry1;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/tbdl_back.sv =====
// Back end: takes entries from the queue, classifies code blocks by address
// range and holds the result in the output register. Depends on tbdl_pkg.
`default_nettype none
module tbdl_back
   import tbdl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  qstat_type  q_stat,
   output logic       pop,
   tbdl_rsp_if.source rsp_chan
);

   logic        valid_ff, valid_in;
   entry_type   ent_ff;
   role_type    role_ff, role_in;
   logic [16:0] end_sum;

   assign pop      = q_stat.not_empty && (!valid_ff || rsp_chan.ready);
   assign valid_in = pop || (valid_ff && !rsp_chan.ready);
   assign end_sum  = {1'b0, head.p1} + {1'b0, head.decl};

   always_comb begin
      if (head.btype != CODE_TYPE) begin
         role_in = ROLE_NONE;
      end else if ((head.p1 == SCREEN_BASE) && (head.decl == SCREEN_SIZE)) begin
         role_in = ROLE_FULL_SCREEN;
      end else if (head.decl == SCREEN_SIZE) begin
         role_in = ROLE_SCREEN_DATA;
      end else if ((head.p1 >= SCREEN_BASE) && (end_sum <= {1'b0, ATTR_BASE})) begin
         role_in = ROLE_BITMAP;
      end else if ((head.p1 == ATTR_BASE) && (head.decl == ATTR_SIZE)) begin
         role_in = ROLE_ATTRS;
      end else if ((head.p1 >= ATTR_BASE) && (end_sum <= {1'b0, PROG_BASE})) begin
         role_in = ROLE_PART_ATTRS;
      end else if (head.p1 >= PROG_BASE) begin
         role_in = ROLE_PROGRAM;
      end else begin
         role_in = ROLE_OTHER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ent_ff  <= head;
         role_ff <= role_in;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.entry_kind      = 3'(ent_ff.kind);
   assign rsp_chan.entry_number    = ent_ff.number;
   assign rsp_chan.block_type      = ent_ff.btype;
   assign rsp_chan.code_role       = 3'(role_ff);
   assign rsp_chan.entry_size      = ent_ff.pay;
   assign rsp_chan.declared_length = ent_ff.decl;
   assign rsp_chan.first_param     = ent_ff.p1;
   assign rsp_chan.second_param    = ent_ff.p2;
   assign rsp_chan.last_of_run     = ent_ff.last;

endmodule
`default_nettype wire

// ===== rtl/core/tape_block_deframer_lister_unit.sv =====
// Tape block deframer and lister, top level: front end, entry queue, back end.
// Depends on tbdl_pkg, tbdl_channels, tbdl_front, tbdl_queue and tbdl_back.
//
// Takes one tape image byte per cycle on req_chan and lists each tape block as
// it closes on rsp_chan: header-only, paired file, raw data, non-ROM block,
// and at end of image a truncated block or trailing byte. A byte that closes
// a block can yield two entries; those go into a QUEUE_DEPTH-entry queue, and
// the input takes a byte in any cycle in which the queue has room for two.
// With the output drained every cycle, the rate is one byte per cycle, and the
// two entries of one byte leave the output register one after the other. A
// closing byte's first entry passes the queue and then the output register.
`default_nettype none
module tape_block_deframer_lister_unit
   import tbdl_pkg::*;
#(
   parameter int QUEUE_DEPTH = TBDL_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   tbdl_req_if.sink   req_chan,
   tbdl_rsp_if.source rsp_chan
);

   push_type  push;
   entry_type entry0, entry1, head;
   qstat_type q_stat;
   logic      pop;

   tbdl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .entry0   (entry0),
      .entry1   (entry1)
   );

   tbdl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .entry0 (entry0),
      .entry1 (entry1),
      .pop    (pop),
      .head   (head),
      .q_stat (q_stat)
   );

   tbdl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

// ===== rtl/core/tbdl_checker.sv =====
// Port-level checks of the tape block deframer and lister, bound to the top.
// Depends on tbdl_pkg.
`default_nettype none
module tbdl_checker
   import tbdl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_entry_kind,
   input logic [15:0] rsp_entry_number,
   input logic [7:0]  rsp_block_type,
   input logic [2:0]  rsp_code_role,
   input logic [15:0] rsp_entry_size
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_kind) &&
      $stable(rsp_entry_number) && $stable(rsp_entry_size))
      else $error("stalled item changed");

   a_err_unnumbered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_kind == 3'(KIND_TRUNC) || rsp_entry_kind == 3'(KIND_TRAIL))
      |-> rsp_entry_number == '0)
      else $error("error item carries an entry number");

   a_role_code_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_type != CODE_TYPE |-> rsp_code_role == 3'(ROLE_NONE))
      else $error("code role on a non-code block");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("item shown right after reset");

endmodule

bind tape_block_deframer_lister_unit tbdl_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_entry_kind   (rsp_chan.entry_kind),
   .rsp_entry_number (rsp_chan.entry_number),
   .rsp_block_type   (rsp_chan.block_type),
   .rsp_code_role    (rsp_chan.code_role),
   .rsp_entry_size   (rsp_chan.entry_size)
);
`default_nettype wire
